// ===== hdl/spq_pkg.sv =====
package spq_pkg;

    localparam int SLOTS      = 16;
    localparam int PRIO_WIDTH = 8;
    localparam int DATA_WIDTH = 16;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int STATUS_W   = 2;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [PRIO_WIDTH-1:0] t_prio;
    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [STATUS_W-1:0]   t_status;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam t_idx LAST_IDX = t_idx'(SLOTS - 1);

    typedef struct packed {
        logic  wr;
        logic  clr;
        t_idx  idx;
        t_prio prio;
        t_data data;
    } t_wr_req;

    typedef struct packed {
        logic  vld;
        t_prio prio;
        t_data data;
    } t_rd_rsp;

    typedef struct packed {
        t_status status;
        t_prio   prio;
        t_data   data;
    } t_result;

endpackage

// ===== hdl/spq_store.sv =====
module spq_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spq_pkg::t_idx    i_rd_idx,
    input  spq_pkg::t_wr_req i_req,
    output logic             o_cur_vld,
    output spq_pkg::t_rd_rsp o_rsp,
    output spq_pkg::t_cnt    o_count
);
    import spq_pkg::*;

    logic  r_valid [SLOTS];
    t_cnt  r_count;
    t_prio r_prio_mem [SLOTS];
    t_data r_data_mem [SLOTS];
    logic  r_rd_vld;
    t_prio r_rd_prio;
    t_data r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_count <= '0;
        end else begin
            if (i_req.wr) begin
                r_valid[i_req.idx] <= 1'b1;
                r_count            <= r_count + t_cnt'(1);
            end else if (i_req.clr) begin
                r_valid[i_req.idx] <= 1'b0;
                r_count            <= r_count - t_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_prio_mem[i_req.idx] <= i_req.prio;
            r_data_mem[i_req.idx] <= i_req.data;
        end
        r_rd_prio <= r_prio_mem[i_rd_idx];
        r_rd_data <= r_data_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[i_rd_idx];
        end
    end

    assign o_cur_vld  = r_valid[i_rd_idx];
    assign o_rsp.vld  = r_rd_vld;
    assign o_rsp.prio = r_rd_prio;
    assign o_rsp.data = r_rd_data;
    assign o_count    = r_count;

endmodule

// ===== hdl/spq_seq.sv =====
module spq_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_cmd,
    input  spq_pkg::t_prio   i_prio,
    input  spq_pkg::t_data   i_data,
    input  logic             i_cur_vld,
    input  spq_pkg::t_rd_rsp i_rsp,
    input  logic             i_res_take,
    output spq_pkg::t_idx    o_rd_idx,
    output spq_pkg::t_wr_req o_req,
    output logic             o_idle,
    output logic             o_done,
    output spq_pkg::t_result o_res
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_TAKE
    } t_state;

    t_state  r_state;
    t_idx    r_idx;
    logic    r_cmd;
    t_prio   r_in_prio;
    t_data   r_in_data;
    logic    r_cmp_en;
    t_idx    r_cmp_idx;
    logic    r_found;
    t_idx    r_best_idx;
    t_prio   r_best_prio;
    t_data   r_best_data;
    logic    r_done;
    t_result r_res;

    logic    take;
    logic    ins_hit;

    assign take    = r_cmp_en && i_rsp.vld && (!r_found || (i_rsp.prio > r_best_prio));
    assign ins_hit = (r_state == S_SCAN) && (r_cmd == CMD_INSERT) && !i_cur_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmp_en <= 1'b0;
            r_found  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_cmp_en <= (r_state == S_SCAN) && (r_cmd == CMD_REMOVE);
            if (i_res_take) begin
                r_done <= 1'b0;
            end
            if (take) begin
                r_found     <= 1'b1;
                r_best_idx  <= r_cmp_idx;
                r_best_prio <= i_rsp.prio;
                r_best_data <= i_rsp.data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd     <= i_cmd;
                        r_in_prio <= i_prio;
                        r_in_data <= i_data;
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cmd == CMD_INSERT) begin
                        if (ins_hit) begin
                            r_done  <= 1'b1;
                            r_res   <= '{status: ST_DONE, prio: '0, data: '0};
                            r_state <= S_IDLE;
                        end else if (r_idx == LAST_IDX) begin
                            r_done  <= 1'b1;
                            r_res   <= '{status: ST_FULL, prio: '0, data: '0};
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + t_idx'(1);
                        end
                    end else begin
                        r_cmp_idx <= r_idx;
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_idx <= r_idx + t_idx'(1);
                        end
                    end
                end
                S_DRAIN: begin
                    r_state <= S_TAKE;
                end
                S_TAKE: begin
                    r_done <= 1'b1;
                    if (r_found) begin
                        r_res <= '{status: ST_DONE, prio: r_best_prio, data: r_best_data};
                    end else begin
                        r_res <= '{status: ST_EMPTY, prio: '0, data: '0};
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_req.wr   = ins_hit;
        o_req.clr  = (r_state == S_TAKE) && r_found;
        o_req.idx  = (r_state == S_TAKE) ? r_best_idx : r_idx;
        o_req.prio = r_in_prio;
        o_req.data = r_in_data;
    end

    assign o_rd_idx = r_idx;
    assign o_idle   = (r_state == S_IDLE) && !r_done;
    assign o_done   = r_done;
    assign o_res    = r_res;

endmodule

// ===== hdl/slot_priority_queue_unit.sv =====
// Slot priority queue: SLOTS entries of priority and payload, unsorted.
// Input channel i_valid/o_ready carries one command per beat: insert
// (i_entry_priority, i_entry_data) into the lowest free slot, or remove the
// entry of highest priority (lowest slot on ties). Output channel
// o_valid/i_ready returns exactly one result beat per command: status,
// removed priority and payload (zero unless a remove found an entry), and
// occupancy after the command.
// Timing: one comparator walks the slots one per cycle through a memory
// with a registered read port. An insert ends at the first free slot, or
// at the last slot if the store is full; a remove always walks every slot,
// then drains the last read and frees the winning slot. o_ready is high only when
// the sequencer is idle and no result waits for the output register.
// A command may run while the previous result is stalled on i_ready; its
// result then holds inside until the output register frees.
// Reset (i_rst_n low, synchronous) empties every slot, clears occupancy and
// drops any result in flight; no clearing pass is needed.
module slot_priority_queue_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_command,
    input  spq_pkg::t_prio           i_entry_priority,
    input  spq_pkg::t_data           i_entry_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output spq_pkg::t_status         o_status,
    output spq_pkg::t_prio           o_out_priority,
    output spq_pkg::t_data           o_out_data,
    output spq_pkg::t_cnt            o_occupancy
);
    import spq_pkg::*;

    t_idx    rd_idx;
    t_wr_req req;
    logic    cur_vld;
    t_rd_rsp rsp;
    t_cnt    count;
    logic    seq_idle;
    logic    seq_done;
    t_result seq_res;
    logic    res_take;
    logic    start;

    logic    r_out_vld;
    t_result r_out_res;
    t_cnt    r_out_cnt;

    assign start    = i_valid && seq_idle;
    assign res_take = seq_done && (!r_out_vld || i_ready);

    spq_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (rd_idx),
        .i_req     (req),
        .o_cur_vld (cur_vld),
        .o_rsp     (rsp),
        .o_count   (count)
    );

    spq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (i_command),
        .i_prio     (i_entry_priority),
        .i_data     (i_entry_data),
        .i_cur_vld  (cur_vld),
        .i_rsp      (rsp),
        .i_res_take (res_take),
        .o_rd_idx   (rd_idx),
        .o_req      (req),
        .o_idle     (seq_idle),
        .o_done     (seq_done),
        .o_res      (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (res_take) begin
                r_out_vld <= 1'b1;
                r_out_res <= seq_res;
                r_out_cnt <= count;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_ready        = seq_idle;
    assign o_valid        = r_out_vld;
    assign o_status       = r_out_res.status;
    assign o_out_priority = r_out_res.prio;
    assign o_out_data     = r_out_res.data;
    assign o_occupancy    = r_out_cnt;

endmodule

// ===== tb/slot_priority_queue_unit_test.sv =====
module slot_priority_queue_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 830;
    localparam int DRAIN_CYCLES = SLOTS + 8;

    typedef struct packed {
        t_status status;
        t_prio   prio;
        t_data   data;
        t_cnt    occ;
    } t_reply;

    typedef struct packed {
        logic   cmd;
        t_prio  prio;
        t_data  data;
        logic   typed;
        t_reply reply;
    } t_stim_row;

    typedef enum int {FILL_RUN, DRAIN_RUN, MIXED_RUN, TIE_RUN} t_run_mode;

    localparam t_stim_row DIRECTED_ROWS [25] = '{
        '{CMD_REMOVE, 8'h00, 16'h0000, 1'b1, '{ST_EMPTY, 8'h00, 16'h0000, 5'd0}},
        '{CMD_INSERT, 8'h00, 16'h0000, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd1}},
        '{CMD_REMOVE, 8'h00, 16'h0000, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd0}},
        '{CMD_REMOVE, 8'hFF, 16'hFFFF, 1'b1, '{ST_EMPTY, 8'h00, 16'h0000, 5'd0}},
        '{CMD_INSERT, 8'h80, 16'h1234, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd1}},
        '{CMD_INSERT, 8'h80, 16'h5678, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd2}},
        '{CMD_INSERT, 8'h00, 16'h0000, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd3}},
        '{CMD_INSERT, 8'hFF, 16'hFFFF, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd4}},
        '{CMD_INSERT, 8'h7F, 16'h8001, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd5}},
        '{CMD_INSERT, 8'hFF, 16'h0001, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd6}},
        '{CMD_INSERT, 8'h01, 16'hFFFE, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd7}},
        '{CMD_INSERT, 8'h80, 16'hAAAA, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd8}},
        '{CMD_INSERT, 8'h55, 16'h5555, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd9}},
        '{CMD_INSERT, 8'hAA, 16'hAAAA, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd10}},
        '{CMD_INSERT, 8'hFE, 16'h7FFF, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd11}},
        '{CMD_INSERT, 8'h00, 16'hFFFF, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd12}},
        '{CMD_INSERT, 8'h80, 16'h0F0F, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd13}},
        '{CMD_INSERT, 8'h33, 16'hF0F0, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd14}},
        '{CMD_INSERT, 8'hCC, 16'h3C3C, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd15}},
        '{CMD_INSERT, 8'h7F, 16'hC3C3, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd16}},
        '{CMD_INSERT, 8'hFF, 16'hFFFF, 1'b1, '{ST_FULL, 8'h00, 16'h0000, 5'd16}},
        '{CMD_REMOVE, 8'h00, 16'h0000, 1'b0, '{ST_DONE, 8'h00, 16'h0000, 5'd0}},
        '{CMD_REMOVE, 8'h00, 16'h0000, 1'b0, '{ST_DONE, 8'h00, 16'h0000, 5'd0}},
        '{CMD_REMOVE, 8'h00, 16'h0000, 1'b0, '{ST_DONE, 8'h00, 16'h0000, 5'd0}},
        '{CMD_INSERT, 8'h00, 16'h0000, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd14}}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_command;
    logic [7:0]  i_entry_priority;
    logic [15:0] i_entry_data;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [7:0]  o_out_priority;
    logic [15:0] o_out_data;
    logic [4:0]  o_occupancy;

    logic   slot_used [SLOTS];
    t_prio  slot_prio [SLOTS];
    t_data  slot_word [SLOTS];
    t_cnt   live_count;
    t_reply pending_replies [$];
    int     error_count;
    int     quiet_cycles;
    logic   steady_run;

    slot_priority_queue_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_entry_priority (i_entry_priority),
        .i_entry_data     (i_entry_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_out_priority   (o_out_priority),
        .o_out_data       (o_out_data),
        .o_occupancy      (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_reply apply_queue_op(logic cmd, t_prio prio, t_data data);
        t_reply reply;
        int     best;
        reply = '{ST_DONE, '0, '0, '0};
        best = -1;
        if (cmd == CMD_INSERT) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (best < 0 && !slot_used[s]) begin
                    best = s;
                end
            end
            if (best < 0) begin
                reply.status = ST_FULL;
            end else begin
                slot_used[best] = 1'b1;
                slot_prio[best] = prio;
                slot_word[best] = data;
                live_count++;
            end
        end else begin
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_used[s] && (best < 0 || slot_prio[s] > slot_prio[best])) begin
                    best = s;
                end
            end
            if (best < 0) begin
                reply.status = ST_EMPTY;
            end else begin
                slot_used[best] = 1'b0;
                reply.prio = slot_prio[best];
                reply.data = slot_word[best];
                live_count--;
            end
        end
        reply.occ = live_count;
        return reply;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_command(logic cmd, t_prio prio, t_data data, logic hold_off,
                                logic typed, t_reply typed_reply);
        int     gap;
        t_reply reply;
        gap = steady_run ? 0 : $urandom_range(0, 14);
        if (hold_off || gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (hold_off) begin
                do @(posedge i_clk); while (pending_replies.size() != 0);
            end
        end
        i_valid          <= 1'b1;
        i_command        <= cmd;
        i_entry_priority <= prio;
        i_entry_data     <= data;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        reply = apply_queue_op(cmd, prio, data);
        pending_replies.push_back(typed ? typed_reply : reply);
    endtask

    initial begin : command_side
        int        sent;
        int        burst_len;
        logic      first_burst;
        logic      hold;
        logic      cmd;
        t_prio     prio;
        t_run_mode mode;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_command        = CMD_INSERT;
        i_entry_priority = '0;
        i_entry_data     = '0;
        i_ready          = 1'b0;
        steady_run       = 1'b0;
        error_count      = 0;
        live_count       = '0;
        for (int s = 0; s < SLOTS; s++) begin
            slot_used[s] = 1'b0;
            slot_prio[s] = '0;
            slot_word[s] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            send_command(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].prio, DIRECTED_ROWS[r].data,
                         1'b0, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].reply);
        end

        sent = 0;
        first_burst = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            burst_len   = $urandom_range(8, 40);
            mode        = t_run_mode'($urandom_range(0, 3));
            steady_run  = ($urandom_range(0, 4) == 0);
            hold        = first_burst || ($urandom_range(0, 5) == 0);
            first_burst = 1'b0;
            for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
                case (mode)
                    FILL_RUN:  cmd = ($urandom_range(0, 99) < 85) ? CMD_INSERT : CMD_REMOVE;
                    DRAIN_RUN: cmd = ($urandom_range(0, 99) < 15) ? CMD_INSERT : CMD_REMOVE;
                    default:   cmd = ($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_REMOVE;
                endcase
                case (mode == TIE_RUN ? 0 : $urandom_range(0, 3))
                    0:       prio = t_prio'($urandom_range(0, 3));
                    1:       prio = ($urandom_range(0, 1) == 0) ? '0 : '1;
                    default: prio = t_prio'($urandom);
                endcase
                send_command(cmd, prio, t_data'($urandom), hold && k == 0, 1'b0, '0);
                sent++;
            end
        end
        i_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : result_side
        int     stall;
        t_reply got;
        t_reply want;
        do @(negedge i_clk); while (!i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = steady_run ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(negedge i_clk); while (!o_valid);
            got = '{o_status, o_out_priority, o_out_data, o_occupancy};
            @(posedge i_clk);
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected beat, expected none actual status %0d data 0x%0h",
                         $time, got.status, got.data);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                check_field("status", want.status, got.status);
                check_field("out_priority", want.prio, got.prio);
                check_field("out_data", want.data, got.data);
                check_field("occupancy", want.occ, got.occ);
            end
        end
    end

    initial begin : watchdog
        quiet_cycles = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
hdl/spq_pkg.sv
hdl/spq_store.sv
hdl/spq_seq.sv
hdl/slot_priority_queue_unit.sv
tb/slot_priority_queue_unit_test.sv
